[sv/llfl_pkg.sv]
// shared types and codes of the linked list unit
`default_nettype none
package llfl_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned INDEX_OUT_W = 8;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_INS    = 5'b00010,
        S_WALK   = 5'b00100,
        S_UNLINK = 5'b01000,
        S_FIN    = 5'b10000
    } t_state;

endpackage
`default_nettype wire

[sv/linked_list_with_free_list_unit.sv]
// top level of the linked list unit with free list
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tuser: op, tdata: item_value
//  m_axis    out  m_axis_tvalid/m_axis_tready    tuser: status, tdata: node_index
//
// one request at a time; the next is taken once the result sits in the output register
// insert: the free-head link is read at acceptance, then S_INS writes the node and S_FIN
//   loads the result
// remove: S_WALK visits the nodes (up to POOL_DEPTH), then S_UNLINK when the node is
//   unlinked from the middle, then S_FIN; the node and link ram read port sets the pace
// reset clears head, free head, top, state and output valid; the node rams need no clearing pass
// a stalled result holds in the output register while the next request is accepted
`default_nettype none
module linked_list_with_free_list_unit #(
    parameter int unsigned POOL_DEPTH = 256,
    parameter int unsigned ITEM_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] item_value
    input  wire logic [0:0]  s_axis_tuser,   // [0] op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata,   // [7:0] node_index
    output logic      [1:0]  m_axis_tuser    // [1:0] status
);
    import llfl_pkg::*;

    localparam int unsigned IW = $clog2(POOL_DEPTH);
    localparam int unsigned LW = $clog2(POOL_DEPTH + 1);

    logic [IW-1:0]         w_raddr;
    logic [LW-1:0]         w_link_rdata;
    logic [ITEM_WIDTH-1:0] w_item_rdata;
    logic                  w_link_we;
    logic [IW-1:0]         w_link_waddr;
    logic [LW-1:0]         w_link_wdata;
    logic                  w_item_we;
    logic [ITEM_WIDTH-1:0] w_item_wdata;

    llfl_ctrl #(
        .POOL_DEPTH (POOL_DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser[0]),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_raddr       (w_raddr),
        .i_link_rdata  (w_link_rdata),
        .i_item_rdata  (w_item_rdata),
        .o_link_we     (w_link_we),
        .o_link_waddr  (w_link_waddr),
        .o_link_wdata  (w_link_wdata),
        .o_item_we     (w_item_we),
        .o_item_wdata  (w_item_wdata)
    );

    llfl_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (w_link_waddr),
        .i_wdata (w_link_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_link_rdata)
    );

    // item writes only happen on insert, at the same slot as the link write
    llfl_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (POOL_DEPTH)
    ) u_item_ram (
        .i_clk   (i_clk),
        .i_we    (w_item_we),
        .i_waddr (w_link_waddr),
        .i_wdata (w_item_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_item_rdata)
    );

endmodule
`default_nettype wire

[sv/llfl_ram.sv]
// generic single-port-write, registered-read ram
`default_nettype none
module llfl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[sv/llfl_ctrl.sv]
// sequencer: insert, list walk, unlink, free-list push and result register
`default_nettype none
module llfl_ctrl #(
    parameter int unsigned POOL_DEPTH = 256,
    parameter int unsigned ITEM_WIDTH = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [llfl_pkg::DATA_W-1:0]          s_axis_tdata,
    input  wire logic                                 s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic      [llfl_pkg::INDEX_OUT_W-1:0]     m_axis_tdata,
    output logic      [1:0]                           m_axis_tuser,
    output logic      [$clog2(POOL_DEPTH)-1:0]        o_raddr,
    input  wire logic [$clog2(POOL_DEPTH+1)-1:0]      i_link_rdata,
    input  wire logic [ITEM_WIDTH-1:0]                i_item_rdata,
    output logic                                      o_link_we,
    output logic      [$clog2(POOL_DEPTH)-1:0]        o_link_waddr,
    output logic      [$clog2(POOL_DEPTH+1)-1:0]      o_link_wdata,
    output logic                                      o_item_we,
    output logic      [ITEM_WIDTH-1:0]                o_item_wdata
);
    import llfl_pkg::*;

    localparam int unsigned IW = $clog2(POOL_DEPTH);
    localparam int unsigned LW = $clog2(POOL_DEPTH + 1);
    localparam int unsigned PW = (IW > INDEX_OUT_W) ? IW : INDEX_OUT_W;
    localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);

    t_state          r_state, n_state;
    logic [ITEM_WIDTH-1:0] r_key, n_key;
    logic [LW-1:0]   r_head, n_head;
    logic [LW-1:0]   r_free, n_free;
    logic [LW-1:0]   r_top, n_top;
    logic [LW-1:0]   r_cur, n_cur;
    logic [LW-1:0]   r_prev, n_prev;
    logic [LW-1:0]   r_next, n_next;
    logic [LW-1:0]   r_steps, n_steps;
    t_status         r_status, n_status;
    logic [IW-1:0]   r_slot, n_slot;
    logic            r_m_valid, n_m_valid;
    t_status         r_m_status, n_m_status;
    logic [IW-1:0]   r_m_slot, n_m_slot;

    logic [ITEM_WIDTH-1:0] w_key;
    logic [LW-1:0]         w_link;
    logic [PW-1:0]         w_slot_pad;
    logic                  w_accept;

    generate
        if (ITEM_WIDTH <= DATA_W) begin : g_key_narrow
            assign w_key = s_axis_tdata[ITEM_WIDTH-1:0];
        end else begin : g_key_wide
            assign w_key = {{(ITEM_WIDTH - DATA_W){1'b0}}, s_axis_tdata};
        end
    endgenerate

    // a stored link outside the pool reads as null
    assign w_link     = (i_link_rdata < NULL_LINK) ? i_link_rdata : NULL_LINK;
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_slot_pad = PW'(r_m_slot);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = w_slot_pad[INDEX_OUT_W-1:0];
    assign m_axis_tuser  = r_m_status;

    always_comb begin
        n_state    = r_state;
        n_key      = r_key;
        n_head     = r_head;
        n_free     = r_free;
        n_top      = r_top;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_next     = r_next;
        n_steps    = r_steps;
        n_status   = r_status;
        n_slot     = r_slot;
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_status = r_m_status;
        n_m_slot   = r_m_slot;

        o_raddr      = '0;
        o_link_we    = 1'b0;
        o_link_waddr = '0;
        o_link_wdata = r_head;
        o_item_we    = 1'b0;
        o_item_wdata = r_key;

        unique case (r_state)
            S_IDLE: begin
                // look-ahead read: free head for an insert, list head for a remove
                o_raddr = (t_op'(s_axis_tuser) == OP_REMOVE) ? r_head[IW-1:0]
                                                              : r_free[IW-1:0];
                if (w_accept) begin
                    n_key = w_key;
                    if (t_op'(s_axis_tuser) == OP_INSERT) begin
                        n_state = S_INS;
                    end else if (r_head == NULL_LINK) begin
                        n_status = ST_NOT_FOUND;
                        n_slot   = '0;
                        n_state  = S_FIN;
                    end else begin
                        n_cur   = r_head;
                        n_prev  = NULL_LINK;
                        n_steps = '0;
                        n_state = S_WALK;
                    end
                end
            end
            S_INS: begin
                n_state = S_FIN;
                if (r_free != NULL_LINK) begin
                    o_link_we    = 1'b1;
                    o_link_waddr = r_free[IW-1:0];
                    o_item_we    = 1'b1;
                    n_free       = w_link;
                    n_head       = r_free;
                    n_status     = ST_INSERTED;
                    n_slot       = r_free[IW-1:0];
                end else if (r_top < NULL_LINK) begin
                    o_link_we    = 1'b1;
                    o_link_waddr = r_top[IW-1:0];
                    o_item_we    = 1'b1;
                    n_top        = r_top + LW'(1);
                    n_head       = r_top;
                    n_status     = ST_INSERTED;
                    n_slot       = r_top[IW-1:0];
                end else begin
                    n_status = ST_FULL;
                    n_slot   = '0;
                end
            end
            S_WALK: begin
                o_raddr = w_link[IW-1:0];
                if (i_item_rdata == r_key) begin
                    // push the found node onto the free list
                    o_link_we    = 1'b1;
                    o_link_waddr = r_cur[IW-1:0];
                    o_link_wdata = r_free;
                    n_free       = r_cur;
                    n_next       = w_link;
                    n_status     = ST_REMOVED;
                    n_slot       = r_cur[IW-1:0];
                    if (r_prev == NULL_LINK) begin
                        n_head  = w_link;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_UNLINK;
                    end
                end else begin
                    n_prev  = r_cur;
                    n_cur   = w_link;
                    n_steps = r_steps + LW'(1);
                    if (w_link == NULL_LINK || n_steps == NULL_LINK) begin
                        n_status = ST_NOT_FOUND;
                        n_slot   = '0;
                        n_state  = S_FIN;
                    end
                end
            end
            S_UNLINK: begin
                o_link_we    = 1'b1;
                o_link_waddr = r_prev[IW-1:0];
                o_link_wdata = r_next;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_status;
                    n_m_slot   = r_slot;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= NULL_LINK;
            r_free    <= NULL_LINK;
            r_top     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_free    <= n_free;
            r_top     <= n_top;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_next     <= n_next;
        r_steps    <= n_steps;
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_m_status <= n_m_status;
        r_m_slot   <= n_m_slot;
    end

endmodule
`default_nettype wire

[sv/llfl_checker.sv]
// port-level checks for the linked list unit, bound to the top level
`default_nettype none
module llfl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [0:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);
    import llfl_pkg::*;

    logic r_last_op;
    logic w_in_acc;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_op <= 1'b0;
        end else if (w_in_acc) begin
            r_last_op <= s_axis_tuser[0];
        end
    end

    // one request in flight: no new request right after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !s_axis_tready)
        else $error("request accepted while the previous one is still in work");

    // full and not-found carry no slot
    a_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FULL || m_axis_tuser == ST_NOT_FOUND)
        |-> m_axis_tdata == 8'd0)
        else $error("non-zero slot on full or not-found result");

    // status must belong to the kind of request that produced it
    a_status_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |->
        ((r_last_op == OP_REMOVE) ==
         (m_axis_tuser == ST_REMOVED || m_axis_tuser == ST_NOT_FOUND)))
        else $error("result status does not match the request kind");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind linked_list_with_free_list_unit llfl_checker u_llfl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
